/* rtl/bds_pkg.sv */
// batch dose sequencer: shared types, widths, register indexes and constants
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps
`default_nettype none

package bds_pkg;

  localparam int VOL_W      = 30;
  localparam int RATE_W     = 42;
  localparam int CNT_W      = 20;
  localparam int HZ_W       = 7;
  localparam int WIDTH_W    = 17;
  localparam int DSR_W      = 20;
  localparam int STEP_W     = 6;
  localparam int T_W        = 11;
  localparam int PROD_W     = 24;
  localparam int USED_W     = VOL_W + CNT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_LOT_VOLUME       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_IN_LITRES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_SECONDS    = 2'd2;

  typedef logic [1:0] div_sel_t;
  localparam div_sel_t DIV_RATE   = 2'd0;
  localparam div_sel_t DIV_PULSE  = 2'd1;
  localparam div_sel_t DIV_PERSEC = 2'd2;

  localparam logic [STEP_W-1:0] RATE_STEPS   = 6'd42;
  localparam logic [STEP_W-1:0] PULSE_STEPS  = 6'd20;
  localparam logic [STEP_W-1:0] PERSEC_STEPS = 6'd30;

  localparam logic [CNT_W-1:0]   BATCH_SECONDS_RST = 20'd3600;
  localparam logic [9:0]         ML_PER_LITRE      = 10'd1000;
  localparam logic [11:0]        SEC_PER_HOUR      = 12'd3600;
  localparam logic [DSR_W-1:0]   PULSE_NUM         = 20'd624000;
  localparam logic [WIDTH_W-1:0] WIDTH_MIN         = 17'd500;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX         = 17'd70000;
  localparam logic [HZ_W-1:0]    HZ_MAX            = 7'd100;
  localparam logic [3:0]         ROUND_UP_TENTHS   = 4'd7;
  localparam logic [12:0]        RECIP_TEN         = 13'd6554;

  typedef struct packed {
    logic     latch_in;
    logic     div_start;
    div_sel_t div_sel;
    logic     save_rate;
    logic     save_t;
    logic     save_hz;
    logic     save_persec;
    logic     save_used;
    logic     commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_idle;
    logic need_pulse;
    logic need_persec;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/bds_div.sv */
// batch dose sequencer: shared radix-2 restoring divider, one quotient bit per cycle
// depends on bds_pkg
`timescale 1ns / 1ps
`default_nettype none

module bds_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bds_pkg::RATE_W-1:0]  dividend,
  input  logic [bds_pkg::DSR_W-1:0]   divisor,
  input  logic [bds_pkg::STEP_W-1:0]  steps,
  output logic                        idle,
  output logic [bds_pkg::RATE_W-1:0]  quotient
);
  import bds_pkg::*;

  logic              busy_r;
  logic [STEP_W-1:0] cnt_r;
  logic [RATE_W-1:0] dvd_r;
  logic [DSR_W-1:0]  rem_r;
  logic [DSR_W-1:0]  dsr_r;
  logic [DSR_W:0]    partial;
  logic [DSR_W:0]    diff;
  logic              ge;
  logic [DSR_W-1:0]  rem_nxt;

  assign partial = {rem_r, dvd_r[RATE_W-1]};
  assign diff    = partial - {1'b0, dsr_r};
  assign ge      = partial >= {1'b0, dsr_r};
  assign rem_nxt = ge ? diff[DSR_W-1:0] : partial[DSR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[RATE_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign idle     = !busy_r;
  assign quotient = dvd_r;

endmodule

`default_nettype wire

/* rtl/bds_datapath.sv */
// batch dose sequencer: configuration registers, sequencer state, divider and result register
// depends on bds_pkg and bds_div; driven by bds_ctrl through ctrl_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module bds_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bds_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_batch_on,
  input  logic                            in_power_on,
  input  logic                            in_pump_running,
  input  logic                            in_manual_batch,
  input  logic                            in_pulse_seen,
  input  logic [bds_pkg::WIDTH_W-1:0]     in_pulse_width,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [bds_pkg::VOL_W-1:0]       out_residual_ml,
  output logic [bds_pkg::RATE_W-1:0]      out_target_rate_ml_h,
  output logic [bds_pkg::HZ_W-1:0]        out_pulse_hz,
  output logic                            out_dosing_active,
  output logic                            out_run_request,
  output logic                            out_wait_request,
  output logic                            out_pulse_consumed,
  input  bds_pkg::ctrl_cmd_t              cmd,
  output bds_pkg::dp_status_t             status
);
  import bds_pkg::*;

  // configuration
  logic [CFG_DATA_W-1:0] lot_volume_r;
  logic                  litres_r;
  logic [CNT_W-1:0]      batch_seconds_r;

  // latched transaction
  logic               batch_on_r;
  logic               power_on_r;
  logic               pump_running_r;
  logic               manual_batch_r;
  logic               pulse_seen_r;
  logic [WIDTH_W-1:0] pulse_width_r;
  logic [VOL_W-1:0]   vol_r;

  // sequencer state
  logic             launched_r;
  logic             manual_done_r;
  logic [CNT_W-1:0] seconds_count_r;
  logic [VOL_W-1:0] residual_r;
  logic [HZ_W-1:0]  hz_r;

  // intermediate results
  logic [RATE_W-1:0] rate_r;
  logic [T_W-1:0]    t_r;
  logic [PROD_W-1:0] prod_r;
  logic [HZ_W-1:0]   hz_calc_r;
  logic [VOL_W-1:0]  persec_r;
  logic [USED_W-1:0] used_r;

  // result register
  logic              out_valid_r;
  logic [VOL_W-1:0]  out_residual_r;
  logic [RATE_W-1:0] out_rate_r;
  logic [HZ_W-1:0]   out_hz_r;
  logic              out_active_r;
  logic              out_run_r;
  logic              out_wait_r;
  logic              out_consumed_r;

  // divider
  logic [RATE_W-1:0] div_dividend;
  logic [DSR_W-1:0]  div_divisor;
  logic [STEP_W-1:0] div_steps;
  logic              div_idle;
  logic [RATE_W-1:0] div_quotient;

  logic [VOL_W-1:0]  lot_ml;
  logic              width_ok;
  logic [CNT_W-1:0]  cnt_inc;
  logic              cont;
  logic [7:0]        q10;
  logic [T_W-1:0]    q10x10;
  logic [T_W-1:0]    t_rem;

  // next state of one step
  logic             launched_nxt;
  logic             manual_done_nxt;
  logic [CNT_W-1:0] seconds_count_nxt;
  logic [VOL_W-1:0] residual_nxt;
  logic [HZ_W-1:0]  hz_nxt;
  logic             run_nxt;
  logic             wait_nxt;
  logic             consumed_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lot_volume_r    <= '0;
      litres_r        <= 1'b0;
      batch_seconds_r <= BATCH_SECONDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOT_VOLUME:       lot_volume_r    <= cfg_data;
        REG_VOLUME_IN_LITRES: litres_r        <= cfg_data[0];
        REG_BATCH_SECONDS:    batch_seconds_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign lot_ml = VOL_W'(lot_volume_r) * VOL_W'(ML_PER_LITRE);

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      batch_on_r     <= in_batch_on;
      power_on_r     <= in_power_on;
      pump_running_r <= in_pump_running;
      manual_batch_r <= in_manual_batch;
      pulse_seen_r   <= in_pulse_seen;
      pulse_width_r  <= in_pulse_width;
      vol_r          <= litres_r ? lot_ml : VOL_W'(lot_volume_r);
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      DIV_RATE: begin
        div_dividend = RATE_W'(vol_r) * RATE_W'(SEC_PER_HOUR);
        div_divisor  = batch_seconds_r;
        div_steps    = RATE_STEPS;
      end
      DIV_PULSE: begin
        div_dividend = {PULSE_NUM, {(RATE_W-DSR_W){1'b0}}};
        div_divisor  = DSR_W'(pulse_width_r);
        div_steps    = PULSE_STEPS;
      end
      DIV_PERSEC: begin
        div_dividend = {vol_r, {(RATE_W-VOL_W){1'b0}}};
        div_divisor  = batch_seconds_r;
        div_steps    = PERSEC_STEPS;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = batch_seconds_r;
        div_steps    = RATE_STEPS;
      end
    endcase
  end

  bds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .idle     (div_idle),
    .quotient (div_quotient)
  );

  assign width_ok = (pulse_width_r > WIDTH_MIN) && (pulse_width_r < WIDTH_MAX);
  assign cnt_inc  = seconds_count_r + 1'b1;
  assign cont     = cnt_inc < batch_seconds_r;

  assign status.div_idle    = div_idle;
  assign status.need_pulse  = batch_on_r && power_on_r && !launched_r && !manual_batch_r &&
                              pulse_seen_r && width_ok;
  assign status.need_persec = batch_on_r && power_on_r && launched_r && pump_running_r && cont;
  assign status.out_free    = !out_valid_r || !out_stall;

  // divide by ten through a reciprocal, exact for the quotient range of the pulse path
  assign q10    = prod_r[PROD_W-1:16];
  assign q10x10 = {q10, 3'b000} + {2'b00, q10, 1'b0};
  assign t_rem  = t_r - q10x10;

  always_ff @(posedge clk) begin
    if (cmd.save_rate) begin
      rate_r <= (batch_seconds_r == '0) ? '0 : div_quotient;
    end
    if (cmd.save_t) begin
      t_r    <= div_quotient[T_W-1:0];
      prod_r <= PROD_W'(div_quotient[T_W-1:0]) * PROD_W'(RECIP_TEN);
    end
    if (cmd.save_hz) begin
      hz_calc_r <= HZ_W'(q10) + HZ_W'(t_rem[3:0] >= ROUND_UP_TENTHS);
    end
    if (cmd.save_persec) begin
      persec_r <= div_quotient[VOL_W-1:0];
    end
    if (cmd.save_used) begin
      used_r <= USED_W'(persec_r) * USED_W'(cnt_inc);
    end
  end

  always_comb begin
    launched_nxt      = launched_r;
    manual_done_nxt   = manual_done_r;
    seconds_count_nxt = seconds_count_r;
    residual_nxt      = residual_r;
    hz_nxt            = hz_r;
    run_nxt           = 1'b0;
    wait_nxt          = 1'b0;
    consumed_nxt      = 1'b0;
    if (batch_on_r) begin
      if (power_on_r) begin
        if (!launched_r) begin
          wait_nxt = 1'b1;
          if (!manual_batch_r) begin
            if (pulse_seen_r) begin
              if (width_ok) begin
                hz_nxt = hz_calc_r;
              end
              consumed_nxt = 1'b1;
              if ((hz_nxt != '0) && (hz_nxt <= HZ_MAX)) begin
                launched_nxt = 1'b1;
                run_nxt      = 1'b1;
              end
            end
          end else if (!manual_done_r) begin
            launched_nxt = 1'b1;
            run_nxt      = 1'b1;
          end
        end else if (pump_running_r) begin
          seconds_count_nxt = cnt_inc;
          if (cont) begin
            residual_nxt = ({{CNT_W{1'b0}}, vol_r} > used_r) ?
                           (vol_r - used_r[VOL_W-1:0]) : '0;
            run_nxt      = 1'b1;
          end else begin
            launched_nxt      = 1'b0;
            seconds_count_nxt = '0;
            consumed_nxt      = 1'b1;
            if (manual_batch_r) begin
              manual_done_nxt = 1'b1;
            end
            residual_nxt = vol_r;
            wait_nxt     = 1'b1;
          end
        end else begin
          run_nxt = 1'b1;
        end
      end else begin
        manual_done_nxt   = 1'b0;
        launched_nxt      = 1'b0;
        seconds_count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launched_r      <= 1'b0;
      manual_done_r   <= 1'b0;
      seconds_count_r <= '0;
      residual_r      <= '0;
      hz_r            <= '0;
    end else if (cmd.commit) begin
      launched_r      <= launched_nxt;
      manual_done_r   <= manual_done_nxt;
      seconds_count_r <= seconds_count_nxt;
      residual_r      <= residual_nxt;
      hz_r            <= hz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_residual_r <= residual_nxt;
      out_rate_r     <= rate_r;
      out_hz_r       <= hz_nxt;
      out_active_r   <= launched_nxt;
      out_run_r      <= run_nxt;
      out_wait_r     <= wait_nxt;
      out_consumed_r <= consumed_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_residual_ml      = out_residual_r;
  assign out_target_rate_ml_h = out_rate_r;
  assign out_pulse_hz         = out_hz_r;
  assign out_dosing_active    = out_active_r;
  assign out_run_request      = out_run_r;
  assign out_wait_request     = out_wait_r;
  assign out_pulse_consumed   = out_consumed_r;

  a_commit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("result committed over an untaken transaction");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> div_idle)
    else $error("divider started while busy");

  a_run_implies_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_run_r) |-> out_active_r)
    else $error("run request without an active batch");

  a_consumed_implies_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_consumed_r) |-> out_wait_r)
    else $error("pulse consumed outside a waiting or end step");

endmodule

`default_nettype wire

/* rtl/bds_ctrl.sv */
// batch dose sequencer: controller state machine sequencing the shared divider
// depends on bds_pkg; commands bds_datapath through ctrl_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module bds_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bds_pkg::dp_status_t  status,
  output bds_pkg::ctrl_cmd_t   cmd
);
  import bds_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_RATE   = 3'd2;
  localparam logic [2:0] S_PULSE  = 3'd3;
  localparam logic [2:0] S_HZ     = 3'd4;
  localparam logic [2:0] S_PERSEC = 3'd5;
  localparam logic [2:0] S_MUL    = 3'd6;
  localparam logic [2:0] S_COMMIT = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_PREP;
        end
      end
      S_PREP: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RATE;
        state_nxt     = S_RATE;
      end
      S_RATE: begin
        if (status.div_idle) begin
          cmd.save_rate = 1'b1;
          if (status.need_pulse) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_PULSE;
            state_nxt     = S_PULSE;
          end else if (status.need_persec) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_PERSEC;
            state_nxt     = S_PERSEC;
          end else begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_PULSE: begin
        if (status.div_idle) begin
          cmd.save_t = 1'b1;
          state_nxt  = S_HZ;
        end
      end
      S_HZ: begin
        cmd.save_hz = 1'b1;
        state_nxt   = S_COMMIT;
      end
      S_PERSEC: begin
        if (status.div_idle) begin
          cmd.save_persec = 1'b1;
          state_nxt       = S_MUL;
        end
      end
      S_MUL: begin
        cmd.save_used = 1'b1;
        state_nxt     = S_COMMIT;
      end
      S_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_PREP))
    else $error("accepted transaction did not start processing");

  a_commit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !in_stall)
    else $error("controller not ready after commit");

  a_single_save: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.save_rate, cmd.save_t, cmd.save_hz, cmd.save_persec, cmd.save_used,
              cmd.commit}) || (cmd.save_rate && cmd.div_start))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

/* rtl/batch_dose_sequencer_core.sv */
// batch dose sequencer: top level joining controller and datapath
// depends on bds_pkg, bds_ctrl, bds_datapath (and bds_div below it)
// usage:
//   input channel in_*: one transaction per one-second tick, taken when in_valid is high
//   and in_stall is low. result channel out_*: exactly one transaction per input, with
//   out_valid held and the payload stable while out_stall is high.
//   configuration: cfg_we writes cfg_data to register cfg_index (0 lot volume, 1 litre
//   unit, 2 batch seconds); other indexes are ignored; write only while idle.
// sequencing:
//   the shared one-bit-per-cycle divider runs each division in turn. every tick runs the
//   42-step rate division; a waiting tick with an in-range pulse measurement adds a
//   20-step division, and a counting tick adds a 30-step division and a multiply.
//   a new transaction is taken only after the previous one has committed its result.
// reset (rst_n low, synchronous): sequencer state cleared, batch seconds set to 3600,
//   no result pending.
// stall: the result waits in the output register; a new transaction is still accepted
//   and processed, and its result is held back until the pending one is taken.
`timescale 1ns / 1ps
`default_nettype none

module batch_dose_sequencer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bds_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_batch_on,
  input  logic                            in_power_on,
  input  logic                            in_pump_running,
  input  logic                            in_manual_batch,
  input  logic                            in_pulse_seen,
  input  logic [bds_pkg::WIDTH_W-1:0]     in_pulse_width,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bds_pkg::VOL_W-1:0]       out_residual_ml,
  output logic [bds_pkg::RATE_W-1:0]      out_target_rate_ml_h,
  output logic [bds_pkg::HZ_W-1:0]        out_pulse_hz,
  output logic                            out_dosing_active,
  output logic                            out_run_request,
  output logic                            out_wait_request,
  output logic                            out_pulse_consumed
);
  import bds_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bds_datapath u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_batch_on          (in_batch_on),
    .in_power_on          (in_power_on),
    .in_pump_running      (in_pump_running),
    .in_manual_batch      (in_manual_batch),
    .in_pulse_seen        (in_pulse_seen),
    .in_pulse_width       (in_pulse_width),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_residual_ml      (out_residual_ml),
    .out_target_rate_ml_h (out_target_rate_ml_h),
    .out_pulse_hz         (out_pulse_hz),
    .out_dosing_active    (out_dosing_active),
    .out_run_request      (out_run_request),
    .out_wait_request     (out_wait_request),
    .out_pulse_consumed   (out_pulse_consumed),
    .cmd                  (cmd),
    .status               (status)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_batch_dose_sequencer_core.sv */
// self-checking testbench for batch_dose_sequencer_core: directed table, then random ticks
// in several register settings, each result checked against its typed table row or an in-bench dose predictor
// depends on bds_pkg and the rtl of batch_dose_sequencer_core
`timescale 1ns / 1ps

module tb_batch_dose_sequencer_core;
  import bds_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 9;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int HOLD_CYCLES   = 600;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_TICKS   = 85;
  localparam int PRINT_CAP     = 40;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // directed setting: 10 litres over 4 seconds, 2500 ml per second
  localparam logic [CFG_DATA_W-1:0] DIR_LOT  = 20'd10;
  localparam logic [CFG_DATA_W-1:0] DIR_SECS = 20'd4;
  localparam logic [RATE_W-1:0]     DIR_RATE = 42'd9000000;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  typedef struct packed {
    logic               batch_on;
    logic               power_on;
    logic               pump_running;
    logic               manual_batch;
    logic               pulse_seen;
    logic [WIDTH_W-1:0] pulse_width;
  } tick_t;

  typedef struct packed {
    logic [VOL_W-1:0]  residual;
    logic [RATE_W-1:0] rate;
    logic [HZ_W-1:0]   hz;
    logic              active;
    logic              run_req;
    logic              wait_req;
    logic              consumed;
  } dose_t;

  typedef struct packed {
    tick_t tick;
    logic  typed;
    dose_t want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_batch_on = 1'b0;
  logic                  in_power_on = 1'b0;
  logic                  in_pump_running = 1'b0;
  logic                  in_manual_batch = 1'b0;
  logic                  in_pulse_seen = 1'b0;
  logic [WIDTH_W-1:0]    in_pulse_width = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [VOL_W-1:0]      out_residual_ml;
  logic [RATE_W-1:0]     out_target_rate_ml_h;
  logic [HZ_W-1:0]       out_pulse_hz;
  logic                  out_dosing_active;
  logic                  out_run_request;
  logic                  out_wait_request;
  logic                  out_pulse_consumed;

  batch_dose_sequencer_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_batch_on          (in_batch_on),
    .in_power_on          (in_power_on),
    .in_pump_running      (in_pump_running),
    .in_manual_batch      (in_manual_batch),
    .in_pulse_seen        (in_pulse_seen),
    .in_pulse_width       (in_pulse_width),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_residual_ml      (out_residual_ml),
    .out_target_rate_ml_h (out_target_rate_ml_h),
    .out_pulse_hz         (out_pulse_hz),
    .out_dosing_active    (out_dosing_active),
    .out_run_request      (out_run_request),
    .out_wait_request     (out_wait_request),
    .out_pulse_consumed   (out_pulse_consumed)
  );

  always #CLK_HALF clk = ~clk;

  // predictor copy of the registers and the sequencer state
  logic [CFG_DATA_W-1:0] cf_lot = '0;
  logic                  cf_litres = 1'b0;
  logic [CNT_W-1:0]      cf_secs = BATCH_SECONDS_RST;
  logic                  st_launched = 1'b0;
  logic                  st_manual_done = 1'b0;
  logic [CNT_W-1:0]      st_seconds = '0;
  logic [VOL_W-1:0]      st_residual = '0;
  logic [HZ_W-1:0]       st_hz = '0;

  dose_t expected_doses[$];
  int    cycle_count = 0;
  int    mismatches = 0;
  int    n_ticks = 0;
  int    n_settings = 0;
  int    n_launches = 0;
  int    n_batch_ends = 0;
  int    burst_left = 0;
  bit    hold_go = 1'b0;

  function automatic dose_t dose_step(tick_t t);
    dose_t       r;
    logic [63:0] vol;
    logic [63:0] rate;
    logic [63:0] used;
    logic [63:0] tenths;
    r = '0;
    vol = cf_litres ? (64'(cf_lot) * 64'(ML_PER_LITRE)) & 64'h3FFF_FFFF : 64'(cf_lot);
    rate = (cf_secs != 0) ? (vol * 64'(SEC_PER_HOUR)) / 64'(cf_secs) : 64'd0;
    if (t.batch_on) begin
      if (t.power_on) begin
        if (!st_launched) begin
          r.wait_req = 1'b1;
          if (!t.manual_batch) begin
            if (t.pulse_seen) begin
              if (t.pulse_width > WIDTH_MIN && t.pulse_width < WIDTH_MAX) begin
                tenths = 64'(PULSE_NUM) / 64'(t.pulse_width);
                st_hz = HZ_W'(tenths / 10 + ((tenths % 10 >= 64'(ROUND_UP_TENTHS)) ? 1 : 0));
              end
              r.consumed = 1'b1;
              if (st_hz != 0 && st_hz <= HZ_MAX) begin
                st_launched = 1'b1;
                r.run_req = 1'b1;
              end
            end
          end else if (!st_manual_done) begin
            st_launched = 1'b1;
            r.run_req = 1'b1;
          end
          if (st_launched) n_launches++;
        end else if (t.pump_running) begin
          st_seconds = st_seconds + 1'b1;
          if (st_seconds < cf_secs) begin
            used = (rate / 64'(SEC_PER_HOUR)) * 64'(st_seconds);
            st_residual = (vol > used) ? VOL_W'(vol - used) : '0;
            r.run_req = 1'b1;
          end else begin
            st_launched = 1'b0;
            st_seconds = '0;
            r.consumed = 1'b1;
            if (t.manual_batch) st_manual_done = 1'b1;
            st_residual = VOL_W'(vol);
            r.wait_req = 1'b1;
            n_batch_ends++;
          end
        end else begin
          r.run_req = 1'b1;
        end
      end else begin
        st_manual_done = 1'b0;
        st_launched = 1'b0;
        st_seconds = '0;
      end
    end
    r.residual = st_residual;
    r.rate = RATE_W'(rate);
    r.hz = st_hz;
    r.active = st_launched;
    return r;
  endfunction

  // flags are {batch_on, power_on, pump_running, manual_batch, pulse_seen}
  // strobes are {dosing_active, run_request, wait_request, pulse_consumed}
  function automatic dir_row_t mk_row(logic [4:0] flags, logic [WIDTH_W-1:0] w, logic typed,
                                      logic [VOL_W-1:0] res, logic [HZ_W-1:0] hz,
                                      logic [3:0] strobes);
    dir_row_t row;
    row.tick = {flags, w};
    row.typed = typed;
    row.want = {res, DIR_RATE, hz, strobes};
    return row;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    if ($urandom_range(0, 4) == 0) begin
      t = tick_t'(22'($urandom));
    end else begin
      t.batch_on     = ($urandom_range(0, 19) != 0);
      t.power_on     = ($urandom_range(0, 14) != 0);
      t.pump_running = ($urandom_range(0, 6) != 0);
      t.manual_batch = ($urandom_range(0, 7) == 0);
      t.pulse_seen   = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2:    t.pulse_width = WIDTH_W'($urandom_range(624, 6240));
        3, 4, 5:    t.pulse_width = WIDTH_W'($urandom_range(624, 69999));
        6:          t.pulse_width = WIDTH_W'($urandom_range(501, 623));
        7: begin
          case ($urandom_range(0, 3))
            0:       t.pulse_width = WIDTH_MIN;
            1:       t.pulse_width = WIDTH_MIN + 1'b1;
            2:       t.pulse_width = WIDTH_MAX - 1'b1;
            default: t.pulse_width = WIDTH_MAX;
          endcase
        end
        8:          t.pulse_width = WIDTH_W'($urandom_range(0, 500));
        default:    t.pulse_width = WIDTH_W'($urandom);
      endcase
    end
    return t;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_LOT_VOLUME:       cf_lot = data;
      REG_VOLUME_IN_LITRES: cf_litres = data[0];
      REG_BATCH_SECONDS:    cf_secs = data;
      default: ;
    endcase
  endtask

  task automatic load_setting(logic [CFG_DATA_W-1:0] lot, logic litres,
                              logic [CFG_DATA_W-1:0] secs);
    write_reg(REG_LOT_VOLUME, lot);
    write_reg(REG_VOLUME_IN_LITRES, {19'($urandom), litres});
    write_reg(REG_BATCH_SECONDS, secs);
    write_reg(REG_UNUSED, 20'($urandom));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic send_tick(tick_t t, logic typed, dose_t want);
    int    gap;
    dose_t got;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_valid        <= 1'b1;
    in_batch_on     <= t.batch_on;
    in_power_on     <= t.power_on;
    in_pump_running <= t.pump_running;
    in_manual_batch <= t.manual_batch;
    in_pulse_seen   <= t.pulse_seen;
    in_pulse_width  <= t.pulse_width;
    do @(posedge clk); while (in_stall);
    got = dose_step(t);
    expected_doses.push_back(typed ? want : got);
    n_ticks++;
    burst_left--;
  endtask

  task automatic drain_phase();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_doses.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count,
               expected_doses.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: stall pattern of its own plus one long hold-off on request
  initial begin
    stall_mode_e mode;
    int          mode_left;
    int          hold_left;
    mode = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_go && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_go = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
          STALL_PERIODIC: out_stall <= ((cycle_count % 16) < 5);
          default:        out_stall <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    dose_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_doses.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = expected_doses.pop_front();
        if (out_residual_ml !== want.residual)
          report_mismatch($sformatf("residual_ml got %0d want %0d", out_residual_ml,
                                    want.residual));
        if (out_target_rate_ml_h !== want.rate)
          report_mismatch($sformatf("target_rate_ml_h got %0d want %0d",
                                    out_target_rate_ml_h, want.rate));
        if (out_pulse_hz !== want.hz)
          report_mismatch($sformatf("pulse_hz got %0d want %0d", out_pulse_hz, want.hz));
        if (out_dosing_active !== want.active)
          report_mismatch($sformatf("dosing_active got %b want %b", out_dosing_active,
                                    want.active));
        if (out_run_request !== want.run_req)
          report_mismatch($sformatf("run_request got %b want %b", out_run_request,
                                    want.run_req));
        if (out_wait_request !== want.wait_req)
          report_mismatch($sformatf("wait_request got %b want %b", out_wait_request,
                                    want.wait_req));
        if (out_pulse_consumed !== want.consumed)
          report_mismatch($sformatf("pulse_consumed got %b want %b", out_pulse_consumed,
                                    want.consumed));
      end
    end
  end

  initial begin
    dir_row_t              dir_rows[$];
    logic [CFG_DATA_W-1:0] lot;
    logic                  litres;
    logic [CFG_DATA_W-1:0] secs;
    int                    sel;

    dir_rows = '{
      mk_row(5'b01111, 17'h1FFFF, 1'b1, 30'd0,     7'd0,   4'b0000),  // not batch mode
      mk_row(5'b10111, 17'd0,     1'b1, 30'd0,     7'd0,   4'b0000),  // power off
      mk_row(5'b11100, 17'd0,     1'b1, 30'd0,     7'd0,   4'b0010),  // waiting, no pulse
      mk_row(5'b11101, 17'd500,   1'b1, 30'd0,     7'd0,   4'b0011),  // width at low bound
      mk_row(5'b11101, 17'd70000, 1'b1, 30'd0,     7'd0,   4'b0011),  // width at high bound
      mk_row(5'b11101, 17'd501,   1'b1, 30'd0,     7'd124, 4'b0011),  // too fast
      mk_row(5'b11101, 17'd69999, 1'b1, 30'd0,     7'd1,   4'b1111),  // rounds up, launch
      mk_row(5'b11000, 17'd0,     1'b1, 30'd0,     7'd1,   4'b1100),  // pump off
      mk_row(5'b11100, 17'd0,     1'b1, 30'd7500,  7'd1,   4'b1100),
      mk_row(5'b11100, 17'd0,     1'b1, 30'd5000,  7'd1,   4'b1100),
      mk_row(5'b11100, 17'd0,     1'b1, 30'd2500,  7'd1,   4'b1100),
      mk_row(5'b11100, 17'd0,     1'b1, 30'd10000, 7'd1,   4'b0011),  // batch end
      mk_row(5'b11001, 17'd0,     1'b1, 30'd10000, 7'd1,   4'b1111),  // stale hz launches
      mk_row(5'b10000, 17'd0,     1'b1, 30'd10000, 7'd1,   4'b0000),  // power off mid run
      mk_row(5'b11010, 17'd0,     1'b1, 30'd10000, 7'd1,   4'b1110),  // manual launch
      mk_row(5'b11110, 17'd0,     1'b0, 30'd0,     7'd0,   4'b0000),
      mk_row(5'b11110, 17'd0,     1'b0, 30'd0,     7'd0,   4'b0000),
      mk_row(5'b11110, 17'd0,     1'b0, 30'd0,     7'd0,   4'b0000),
      mk_row(5'b11110, 17'd0,     1'b1, 30'd10000, 7'd1,   4'b0011),  // manual batch end
      mk_row(5'b11010, 17'd0,     1'b1, 30'd10000, 7'd1,   4'b0010),  // manual already done
      mk_row(5'b11011, 17'd1230,  1'b0, 30'd0,     7'd0,   4'b0000),
      mk_row(5'b11001, 17'd1230,  1'b1, 30'd10000, 7'd51,  4'b1111),
      mk_row(5'b11111, 17'h1FFFF, 1'b1, 30'd7500,  7'd51,  4'b1100),
      mk_row(5'b10111, 17'h1FFFF, 1'b1, 30'd7500,  7'd51,  4'b0000),  // clears manual done
      mk_row(5'b11010, 17'd0,     1'b1, 30'd7500,  7'd51,  4'b1110)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_setting(DIR_LOT, 1'b1, DIR_SECS);
    foreach (dir_rows[i]) send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);
    drain_phase();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin lot = 20'd999999;   litres = 1'b1; secs = 20'd0;      end
        1: begin lot = 20'hFFFFF;    litres = 1'b1; secs = 20'd1;      end
        2: begin lot = 20'd0;        litres = 1'b0; secs = 20'hFFFFF;  end
        3: begin lot = 20'hFFFFF;    litres = 1'b0; secs = 20'd5;      end
        default: begin
          lot = ($urandom_range(0, 1) == 0) ? 20'($urandom) : 20'($urandom_range(0, 5000));
          litres = 1'($urandom);
          sel = $urandom_range(0, 19);
          if (sel < 3)       secs = 20'd0;
          else if (sel < 17) secs = 20'($urandom_range(1, 12));
          else               secs = 20'($urandom);
        end
      endcase
      load_setting(lot, litres, secs);
      // the receiver holds off long enough for the input to back up
      if (p == 3) hold_go = 1'b1;
      for (int k = 0; k < PHASE_TICKS; k++) send_tick(random_tick(), 1'b0, '0);
      drain_phase();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d ticks over %0d register settings with %0d launches and %0d batch ends",
             n_ticks, n_settings, n_launches, n_batch_ends);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
